// File: hw/rtl/fpdc_pkg.sv
`timescale 1ns / 1ps

package fpdc_pkg;

   localparam int unsigned MAX_WORD_BITS = 32;

   localparam int unsigned WORD_BITS_W = 6;
   localparam int unsigned FRACTION_BITS_W = 11;
   localparam int unsigned FIXED_W = 32;
   localparam int unsigned DOUBLE_W = 64;

   // exponent arithmetic runs in 13-bit signed
   localparam logic signed [12:0] EXP_BIAS = 13'sd1023;
   localparam logic signed [12:0] EXP_SPAN = 13'sd1024;
   localparam logic signed [12:0] EXP_MAX_FIELD = 13'sd2047;
   localparam logic signed [12:0] EXP_MIN_NORMAL = -13'sd1022;
   localparam logic signed [12:0] SUBNORMAL_BIAS = 13'sd1074;
   localparam logic signed [12:0] MANT_BITS = 13'sd52;
   localparam logic signed [12:0] WORD_LIMIT = 13'sd32;
   localparam logic signed [12:0] ROUND_LIMIT = 13'sd54;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;

   // command codes
   localparam logic CMD_FIXED_TO_DOUBLE = 1'b0;
   localparam logic CMD_DOUBLE_TO_FIXED = 1'b1;

   // register indexes
   localparam logic [1:0] REG_WORD_BITS = 2'd0;
   localparam logic [1:0] REG_FRACTION_BITS = 2'd1;
   localparam logic [1:0] REG_IS_SIGNED = 2'd2;

   typedef struct packed {
      logic [WORD_BITS_W-1:0] word_bits;
      logic [FRACTION_BITS_W-1:0] fraction_bits;
      logic is_signed;
   } cfg_type;

   typedef struct packed {
      logic [DOUBLE_W-1:0] double_result;
      logic [FIXED_W-1:0] fixed_result;
      logic config_error;
   } result_type;

   function automatic logic [4:0] msb32(input logic [31:0] v);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [5:0] msb52(input logic [51:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [31:0] word_mask(input logic [WORD_BITS_W-1:0] wb);
      logic [32:0] m;
      m = (33'h1 << wb) - 33'h1;
      return m[31:0];
   endfunction

endpackage

// File: hw/rtl/fpdc_convert.sv
`timescale 1ns / 1ps

module fpdc_convert (
   input logic command,
   input logic [31:0] fixed_word,
   input logic [63:0] double_bits,
   input fpdc_pkg::cfg_type cfg,
   output fpdc_pkg::result_type result
);

   logic signed [12:0] wb_s;
   logic signed [12:0] fb_s;
   logic format_ok;
   logic [31:0] mask;

   // fixed to double
   logic [5:0] wb_m1;
   logic top_bit;
   logic [31:0] ext_word;
   logic f_neg;
   logic [31:0] f_mag;
   logic [4:0] f_msb;
   logic [31:0] f_norm;
   logic signed [12:0] f_exp;
   logic [63:0] f_result;

   // double to fixed
   logic d_sign;
   logic [10:0] d_exp_field;
   logic [51:0] d_frac;
   logic [5:0] d_sub_msb;
   logic [52:0] d_man;
   logic signed [12:0] d_exp;
   logic signed [12:0] d_scaled_exp;
   logic signed [12:0] d_shift;
   logic signed [12:0] d_rshift;
   logic [52:0] d_man_shr;
   logic [31:0] d_mag;
   logic [31:0] d_value;

   always_comb begin
      wb_s = {7'b0, cfg.word_bits};
      fb_s = {{2{cfg.fraction_bits[10]}}, cfg.fraction_bits};
      format_ok = (cfg.word_bits != '0) && (wb_s <= fpdc_pkg::WORD_LIMIT) &&
                  (fb_s <= fpdc_pkg::EXP_BIAS - wb_s) &&
                  (fb_s >= wb_s - fpdc_pkg::EXP_SPAN);
      mask = fpdc_pkg::word_mask(cfg.word_bits);
   end

   always_comb begin
      wb_m1 = cfg.word_bits - 6'd1;
      top_bit = fixed_word[wb_m1[4:0]];
      ext_word = (cfg.is_signed && top_bit) ? (fixed_word | ~mask) : fixed_word;
      f_neg = cfg.is_signed && ext_word[31];
      f_mag = f_neg ? (32'h0 - ext_word) : ext_word;
      f_msb = fpdc_pkg::msb32(f_mag);
      f_norm = f_mag << (5'd31 - f_msb);
      f_exp = fpdc_pkg::EXP_BIAS + $signed({8'b0, f_msb}) - fb_s;
      if (f_mag == '0) begin
         f_result = '0;
      end else if (f_exp >= fpdc_pkg::EXP_MAX_FIELD) begin
         // overflow to infinity
         f_result = {f_neg, fpdc_pkg::EXP_ALL_ONES, 52'b0};
      end else begin
         f_result = {f_neg, f_exp[10:0], f_norm[30:0], 21'b0};
      end
   end

   always_comb begin
      d_sign = double_bits[63];
      d_exp_field = double_bits[62:52];
      d_frac = double_bits[51:0];
      d_sub_msb = fpdc_pkg::msb52(d_frac);
      if (d_exp_field == '0) begin
         // subnormal input, normalise
         d_man = {1'b0, d_frac} << (6'd52 - d_sub_msb);
         d_exp = $signed({7'b0, d_sub_msb}) - fpdc_pkg::SUBNORMAL_BIAS;
      end else begin
         d_man = {1'b1, d_frac};
         d_exp = $signed({2'b0, d_exp_field}) - fpdc_pkg::EXP_BIAS;
      end
      d_scaled_exp = d_exp + fb_s;
      d_shift = d_scaled_exp - fpdc_pkg::MANT_BITS;
      d_rshift = -d_shift;
      d_man_shr = d_man >> d_rshift[5:0];
      d_mag = '0;
      if (d_exp_field == fpdc_pkg::EXP_ALL_ONES) begin
         d_mag = '0;
      end else if (d_exp_field == '0 && d_frac == '0) begin
         d_mag = '0;
      end else if (d_scaled_exp > fpdc_pkg::EXP_BIAS) begin
         // scaled value is infinite
         d_mag = '0;
      end else if (d_scaled_exp < fpdc_pkg::EXP_MIN_NORMAL) begin
         d_mag = '0;
      end else if (d_shift >= 13'sd0) begin
         if (d_shift >= fpdc_pkg::WORD_LIMIT) begin
            d_mag = '0;
         end else begin
            d_mag = d_man[31:0] << d_shift[4:0];
         end
      end else if (d_rshift >= fpdc_pkg::ROUND_LIMIT) begin
         d_mag = '0;
      end else begin
         // round half away from zero on the magnitude
         d_mag = d_man_shr[31:0] + {31'b0, d_man[d_rshift[5:0] - 6'd1]};
      end
      d_value = d_sign ? (32'h0 - d_mag) : d_mag;
   end

   always_comb begin
      result = '0;
      if (!format_ok) begin
         result.config_error = 1'b1;
      end else if (command == fpdc_pkg::CMD_FIXED_TO_DOUBLE) begin
         result.double_result = f_result;
      end else begin
         result.fixed_result = d_value & mask;
      end
   end

endmodule

// File: hw/rtl/fixed_point_double_converter_top.sv
// fixed-point / binary64 converter
// request channel: req_command selects the direction, req_fixed_word holds the
// raw fixed-point word and req_double_bits the binary64 pattern; the field not
// used by the command is ignored
// response channel: rsp_double_result, rsp_fixed_result and rsp_config_error;
// the result field not belonging to the command is zero, and both are zero
// when the configured format is invalid
// format registers are set over the csr port (word bits at 0x0, fraction bits
// at 0x4, signed flag at 0x8) and should only be written while idle
// latency: the accepting edge loads the request register and the next edge
// loads the result register, so rsp_valid rises one clock edge after the
// request is accepted; one request per cycle is taken while responses are consumed
// when rsp_ready is low the result register holds and the request register
// still takes one more request, after which req_ready drops
// reset clears both stages and loads word bits 32, fraction bits 0, signed 1
`timescale 1ns / 1ps

module fixed_point_double_converter_top (
   input logic clock,
   input logic reset,

   input logic req_valid,
   output logic req_ready,
   input logic req_command,
   input logic [31:0] req_fixed_word,
   input logic [63:0] req_double_bits,

   output logic rsp_valid,
   input logic rsp_ready,
   output logic [63:0] rsp_double_result,
   output logic [31:0] rsp_fixed_result,
   output logic rsp_config_error,

   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [3:0] csr_paddr,
   input logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   fpdc_pkg::cfg_type cfg_ff;
   logic csr_write;
   logic [1:0] csr_index;

   logic s1_valid_ff;
   logic s1_valid_in;
   logic s1_command_ff;
   logic [31:0] s1_fixed_ff;
   logic [63:0] s1_double_ff;

   logic out_valid_ff;
   logic out_valid_in;
   fpdc_pkg::result_type out_ff;
   fpdc_pkg::result_type conv_result;

   logic advance;
   logic req_take;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_bits <= 6'd32;
         cfg_ff.fraction_bits <= '0;
         cfg_ff.is_signed <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            fpdc_pkg::REG_WORD_BITS: begin
               cfg_ff.word_bits <= csr_pwdata[5:0];
            end
            fpdc_pkg::REG_FRACTION_BITS: begin
               cfg_ff.fraction_bits <= csr_pwdata[10:0];
            end
            fpdc_pkg::REG_IS_SIGNED: begin
               cfg_ff.is_signed <= csr_pwdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fpdc_pkg::REG_WORD_BITS: csr_prdata = {26'b0, cfg_ff.word_bits};
         fpdc_pkg::REG_FRACTION_BITS: csr_prdata = {21'b0, cfg_ff.fraction_bits};
         fpdc_pkg::REG_IS_SIGNED: csr_prdata = {31'b0, cfg_ff.is_signed};
         default: csr_prdata = '0;
      endcase
   end

   assign advance = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign req_take = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_command;
         s1_fixed_ff <= req_fixed_word;
         s1_double_ff <= req_double_bits;
      end
      if (advance && s1_valid_ff) begin
         out_ff <= conv_result;
      end
   end

   fpdc_convert u_convert (
      .command(s1_command_ff),
      .fixed_word(s1_fixed_ff),
      .double_bits(s1_double_ff),
      .cfg(cfg_ff),
      .result(conv_result)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_double_result = out_ff.double_result;
   assign rsp_fixed_result = out_ff.fixed_result;
   assign rsp_config_error = out_ff.config_error;

`ifndef NO_ASSERTIONS
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_config_error |-> rsp_double_result == '0 && rsp_fixed_result == '0)
      else $error("config error with non-zero result");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fixed_result != '0 |-> rsp_double_result == '0)
      else $error("both result fields set");

   a_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fixed_result & ~fpdc_pkg::word_mask(cfg_ff.word_bits)) == '0)
      else $error("fixed result wider than word");

   a_request_held: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_double_ff))
      else $error("request stage changed during stall");
`endif

endmodule

// File: bench/fixed_point_double_converter_top_test.sv
`timescale 1ns / 1ps

module fixed_point_double_converter_top_test;

   class conversion_scoreboard;
      logic [fpdc_pkg::WORD_BITS_W-1:0] word_bits;
      logic signed [fpdc_pkg::FRACTION_BITS_W-1:0] fraction_bits;
      logic is_signed;
      fpdc_pkg::result_type expected_q[$];
      int errors;
      int checked;

      function void reset_format();
         word_bits = 6'd32;
         fraction_bits = '0;
         is_signed = 1'b1;
         expected_q.delete();
         errors = 0;
         checked = 0;
      endfunction

      function void set_format(logic [1:0] index, logic [31:0] value);
         case (index)
            fpdc_pkg::REG_WORD_BITS: word_bits = value[fpdc_pkg::WORD_BITS_W-1:0];
            fpdc_pkg::REG_FRACTION_BITS:
               fraction_bits = value[fpdc_pkg::FRACTION_BITS_W-1:0];
            fpdc_pkg::REG_IS_SIGNED: is_signed = value[0];
            default: ;
         endcase
      endfunction

      function real exact_power(int k);
         logic [63:0] b;
         if (k > 1023) k = 1023;
         if (k < -1074) k = -1074;
         if (k >= -1022) b = 64'(k + 1023) << 52;
         else b = 64'h1 << (k + 1074);
         return $bitstoreal(b);
      endfunction

      function logic [63:0] word_to_double(logic [31:0] w);
         logic [63:0] mask;
         logic [31:0] x;
         longint v;
         int frac;
         frac = fraction_bits;
         mask = (64'h1 << word_bits) - 64'h1;
         if (is_signed) begin
            x = w;
            // sign extension only when the top bit of the word is set
            if (w[word_bits-1]) x = w | ~mask[31:0];
            v = longint'(signed'(x));
         end else begin
            v = longint'({32'b0, w});
         end
         return $realtobits(real'(v) * exact_power(-frac));
      endfunction

      function logic [31:0] double_to_word(logic [63:0] in_bits);
         real scaled;
         logic [63:0] b, man, mag, mask;
         int ex, sh, frac;
         frac = fraction_bits;
         scaled = $bitstoreal(in_bits) * exact_power(frac);
         b = $realtobits(scaled);
         ex = int'(b[62:52]);
         man = {12'b0, b[51:0]};
         mask = (64'h1 << word_bits) - 64'h1;
         if (ex == 2047) return 32'h0;
         if (ex == 0) begin
            mag = '0;
         end else begin
            sh = ex - 1075;
            man[52] = 1'b1;
            if (sh >= 64) mag = '0;
            else if (sh >= 0) mag = man << sh;
            else if (-sh >= 54) mag = '0;
            else mag = (man >> (-sh)) + ((man >> (-sh - 1)) & 64'h1);
         end
         if (b[63]) mag = 64'h0 - mag;
         mag = mag & mask;
         return mag[31:0];
      endfunction

      function void note_request(logic cmd, logic [31:0] fw, logic [63:0] db);
         fpdc_pkg::result_type r;
         int wb, frac;
         wb = word_bits;
         frac = fraction_bits;
         r = '0;
         if (wb == 0 || wb > fpdc_pkg::MAX_WORD_BITS || frac > 1023 - wb ||
             frac < -1024 + wb)
            r.config_error = 1'b1;
         else if (cmd == fpdc_pkg::CMD_FIXED_TO_DOUBLE) r.double_result = word_to_double(fw);
         else r.fixed_result = double_to_word(db);
         expected_q.push_back(r);
      endfunction

      function void check_response(fpdc_pkg::result_type got);
         fpdc_pkg::result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.double_result !== want.double_result) begin
            $display("%0t: double_result expected %h actual %h", $time,
                     want.double_result, got.double_result);
            errors++;
         end
         if (got.fixed_result !== want.fixed_result) begin
            $display("%0t: fixed_result expected %h actual %h", $time,
                     want.fixed_result, got.fixed_result);
            errors++;
         end
         if (got.config_error !== want.config_error) begin
            $display("%0t: config_error expected %b actual %b", $time,
                     want.config_error, got.config_error);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [31:0] req_fixed_word = '0;
   logic [63:0] req_double_bits = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_double_result;
   logic [31:0] rsp_fixed_result;
   logic rsp_config_error;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   conversion_scoreboard conversions = new();
   int send_idle_pct;
   int recv_idle_pct;
   int stall_cycles;
   int invalid_formats;

   fixed_point_double_converter_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            conversions.note_request(req_command, req_fixed_word, req_double_bits);
         if (rsp_valid && rsp_ready)
            conversions.check_response({rsp_double_result, rsp_fixed_result,
                                        rsp_config_error});
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles > 20000) begin
            $display("%0t: no progress, giving up", $time);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_request(logic cmd, logic [31:0] fw, logic [63:0] db);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_fixed_word <= fw;
      req_double_bits <= db;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      // let the last accepted request reach the scoreboard first
      @(posedge clock);
      while (conversions.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      conversions.set_format(index, value);
   endtask

   task automatic set_format(int wb, int frac, int sgn);
      csr_write(fpdc_pkg::REG_WORD_BITS, 32'(wb));
      csr_write(fpdc_pkg::REG_FRACTION_BITS, 32'(frac));
      csr_write(fpdc_pkg::REG_IS_SIGNED, 32'(sgn));
      if (wb == 0 || wb > fpdc_pkg::MAX_WORD_BITS || frac > 1023 - wb || frac < -1024 + wb)
         invalid_formats++;
   endtask

   // mostly values that land near the word range after scaling, plus halves and raw noise
   task automatic random_request();
      logic [63:0] db;
      logic [31:0] fw;
      int e;
      int frac;
      frac = conversions.fraction_bits;
      fw = $urandom;
      if ($urandom_range(3) == 0) fw = fw >> $urandom_range(31);
      db = {$urandom, $urandom};
      case ($urandom_range(3))
         0: ;
         1, 2: begin
            e = 1023 - frac + $urandom_range(40) - 4;
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            db[62:52] = 11'(e);
         end
         default: begin
            // one fraction bit set, which lands on an exact half after scaling for some exponents
            e = 1023 - frac + $urandom_range(20);
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            db[62:52] = 11'(e);
            db[51:0] = 52'h8_0000_0000_0000 >> $urandom_range(20);
         end
      endcase
      send_request(1'($urandom_range(1)), fw, db);
   endtask

   initial begin
      logic [31:0] words[5];
      logic [63:0] doubles[16];
      int formats[14][3];
      conversions.reset_format();
      send_idle_pct = 16;
      recv_idle_pct = 88;
      invalid_formats = 0;
      words = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
      doubles = '{64'h0, 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000,
                  64'h3FE0_0000_0000_0000, 64'hBFE0_0000_0000_0000,
                  64'h4004_0000_0000_0000, 64'h3FF8_0000_0000_0000,
                  64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                  64'h7FF8_0000_0000_0001, 64'h4639_8000_0000_0000,
                  64'h0000_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF,
                  64'h41F0_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'hC1E0_0000_0000_0001};
      formats = '{'{1, 0, 0}, '{1, -1023, 1}, '{32, 991, 0}, '{32, -992, 1},
                  '{16, 8, 1}, '{8, -4, 0}, '{0, 0, 1}, '{63, 0, 0},
                  '{4, 1020, 1}, '{32, -1023, 0}, '{24, -1000, 1},
                  '{1, 1022, 0}, '{12, 20, 1}, '{32, 0, 0}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (words[i])
         send_request(fpdc_pkg::CMD_FIXED_TO_DOUBLE, words[i], {$urandom, $urandom});
      foreach (doubles[i]) send_request(fpdc_pkg::CMD_DOUBLE_TO_FIXED, $urandom, doubles[i]);
      drain();

      foreach (formats[p]) begin
         if (p == 5) begin
            send_idle_pct = 88;
            recv_idle_pct = 16;
         end else if (p == 10) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_format(formats[p][0], formats[p][1], formats[p][2]);
         for (int n = 0; n < 45; n++) random_request();
         drain();
      end

      $display("checked %0d responses over %0d formats, %0d of them invalid",
               conversions.checked, 15, invalid_formats);
      $display("both directions, rounding halves, infinities, nan and wrap covered");
      if (conversions.errors == 0 && conversions.expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
